// File: rtl/core/acd_pkg.sv
// shared types and constants of the two-tap adpcm frame decoder
package acd_pkg;

	// samples held in one frame
	localparam int SAMPLES_PER_FRAME = 14;
	localparam logic [3:0] FRAME_SAMPLES = 4'(SAMPLES_PER_FRAME);

	// frame layout
	localparam int NIB_BITS = 4 * SAMPLES_PER_FRAME;

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// clip limits of one pcm sample
	localparam logic signed [23:0] PCM_MAX = 24'sd32767;
	localparam logic signed [23:0] PCM_MIN = -24'sd32768;

	// configuration register indexes
	localparam logic [2:0] REG_COEF_WORD_0     = 3'd0;
	localparam logic [2:0] REG_COEF_WORD_1     = 3'd1;
	localparam logic [2:0] REG_COEF_WORD_2     = 3'd2;
	localparam logic [2:0] REG_COEF_WORD_3     = 3'd3;
	localparam logic [2:0] REG_START_HIST_NEWER = 3'd4;
	localparam logic [2:0] REG_START_HIST_OLDER = 3'd5;

	// configuration as seen by front and back
	typedef struct packed {
		logic [3:0][63:0]   coef_word;
		logic signed [15:0] start_hist_newer;
		logic signed [15:0] start_hist_older;
	} acd_cfg_t;

	// one classified frame waiting for the back end
	typedef struct packed {
		logic [NIB_BITS-1:0] nibbles;
		logic [3:0]          exponent;
		logic signed [15:0]  c1;
		logic signed [15:0]  c2;
		logic [3:0]          total;
		logic                emit;
		logic                restart;
	} acd_job_t;

endpackage

// File: rtl/core/acd_cfg.sv
// configuration register file of the adpcm frame decoder
module acd_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [63:0]       cfg_data,
	output acd_pkg::acd_cfg_t cfg
);

	acd_pkg::acd_cfg_t cfg_q;

	// writes are always taken
	assign cfg_ready = 1'b1;

	// register writes, indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				acd_pkg::REG_COEF_WORD_0: begin
					cfg_q.coef_word[0] <= cfg_data;
				end
				acd_pkg::REG_COEF_WORD_1: begin
					cfg_q.coef_word[1] <= cfg_data;
				end
				acd_pkg::REG_COEF_WORD_2: begin
					cfg_q.coef_word[2] <= cfg_data;
				end
				acd_pkg::REG_COEF_WORD_3: begin
					cfg_q.coef_word[3] <= cfg_data;
				end
				acd_pkg::REG_START_HIST_NEWER: begin
					cfg_q.start_hist_newer <= cfg_data[15:0];
				end
				acd_pkg::REG_START_HIST_OLDER: begin
					cfg_q.start_hist_older <= cfg_data[15:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/core/acd_front.sv
// front end: takes frame items, picks the coefficient pair and queues jobs
module acd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  acd_pkg::acd_cfg_t cfg,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [63:0]       frame_bytes,
	input  logic [3:0]        sample_count,
	input  logic              discard,
	input  logic              restart,
	output logic              job_valid,
	output acd_pkg::acd_job_t job,
	input  logic              job_pop
);

	acd_pkg::acd_job_t queue_q [acd_pkg::QUEUE_DEPTH];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        fill_q;
	acd_pkg::acd_job_t new_job;
	logic [2:0]        pair_idx;
	logic [63:0]       pair_word;
	logic              push;

	// classify the incoming item
	always_comb begin
		pair_idx  = frame_bytes[62:60];
		pair_word = cfg.coef_word[pair_idx[2:1]];
		new_job.nibbles  = frame_bytes[acd_pkg::NIB_BITS-1:0];
		new_job.exponent = frame_bytes[59:56];
		new_job.c1       = pair_idx[0] ? pair_word[47:32] : pair_word[15:0];
		new_job.c2       = pair_idx[0] ? pair_word[63:48] : pair_word[31:16];
		new_job.emit     = !discard;
		new_job.restart  = restart;
		if (discard || sample_count > acd_pkg::FRAME_SAMPLES) begin
			new_job.total = acd_pkg::FRAME_SAMPLES;
		end else begin
			new_job.total = sample_count;
		end
	end

	assign s_tready  = (fill_q != 2'(acd_pkg::QUEUE_DEPTH));
	assign push      = s_tvalid && s_tready;
	assign job_valid = (fill_q != 2'd0);
	assign job       = queue_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= new_job;
		end
	end

	// queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (job_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !job_pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (job_pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

// File: rtl/core/acd_back.sv
// back end: sample sequencer with two-tap prediction and output register
module acd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  acd_pkg::acd_cfg_t cfg,
	input  logic              job_valid,
	input  acd_pkg::acd_job_t job,
	output logic              job_pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [15:0]       pcm_sample,
	output logic              last
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_MUL  = 3'b010,
		ST_ACC  = 3'b100
	} state_t;

	state_t                      state_q;
	logic signed [15:0]          hist_newer_q;
	logic signed [15:0]          hist_older_q;
	logic [acd_pkg::NIB_BITS-1:0] nib_q;
	logic [3:0]                  exp_q;
	logic signed [15:0]          c1_q;
	logic signed [15:0]          c2_q;
	logic [3:0]                  left_q;
	logic                        emit_q;
	logic signed [31:0]          p1_s1;
	logic signed [31:0]          p2_s1;
	logic                        out_valid_q;
	logic [15:0]                 out_sample_q;
	logic                        out_last_q;

	logic signed [32:0] pred_sum;
	logic signed [21:0] pred;
	logic signed [18:0] step;
	logic signed [23:0] raw;
	logic signed [15:0] sample;
	logic               advance;

	assign job_pop = (state_q == ST_IDLE) && job_valid;

	// prediction, scaled nibble and clip
	always_comb begin
		pred_sum = {p1_s1[31], p1_s1} + {p2_s1[31], p2_s1};
		pred     = pred_sum[32:11];
		step     = {{15{nib_q[acd_pkg::NIB_BITS-1]}},
			nib_q[acd_pkg::NIB_BITS-1 -: 4]} << exp_q;
		raw      = {{2{pred[21]}}, pred} + {{5{step[18]}}, step};
		if (raw > acd_pkg::PCM_MAX) begin
			sample = 16'sd32767;
		end else if (raw < acd_pkg::PCM_MIN) begin
			sample = -16'sd32768;
		end else begin
			sample = raw[15:0];
		end
	end

	// a sample retires when its result has room in the output register, or when its frame is discarded
	assign advance = (state_q == ST_ACC) && (!emit_q || !out_valid_q || m_tready);

	// sequencer and history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			hist_newer_q <= '0;
			hist_older_q <= '0;
			left_q       <= '0;
			emit_q       <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						if (job.restart) begin
							hist_newer_q <= cfg.start_hist_newer;
							hist_older_q <= cfg.start_hist_older;
						end
						left_q <= job.total;
						emit_q <= job.emit;
						if (job.total != 4'd0) begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (advance) begin
						hist_older_q <= hist_newer_q;
						hist_newer_q <= sample;
						left_q       <= left_q - 4'd1;
						state_q      <= (left_q == 4'd1) ? ST_IDLE : ST_MUL;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// job payload and products
	always_ff @(posedge clk) begin
		if (job_pop) begin
			nib_q <= job.nibbles;
			exp_q <= job.exponent;
			c1_q  <= job.c1;
			c2_q  <= job.c2;
		end else if (advance) begin
			nib_q <= {nib_q[acd_pkg::NIB_BITS-5:0], 4'd0};
		end
		if (state_q == ST_MUL) begin
			p1_s1 <= hist_newer_q * c1_q;
			p2_s1 <= hist_older_q * c2_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit_q) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit_q) begin
			out_sample_q <= sample;
			out_last_q   <= (left_q == 4'd1);
		end
	end

	assign m_tvalid   = out_valid_q;
	assign pcm_sample = out_sample_q;
	assign last       = out_last_q;

`ifndef SYNTH
	// a running job always has samples left
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (left_q != 4'd0))
		else $error("acd_back: running job with no samples left");

	// a product stage is always followed by its accumulate stage
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |=> (state_q == ST_ACC))
		else $error("acd_back: multiply not followed by accumulate");

	// a result is never overwritten while it waits to be taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |-> !(advance && emit_q))
		else $error("acd_back: pending result overwritten");

	// the final sample of a frame leaves the sequencer idle
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && left_q == 4'd1) |=> (state_q == ST_IDLE))
		else $error("acd_back: sequencer busy after last sample");
`endif

endmodule

// File: rtl/core/adpcm_two_tap_frame_decoder.sv
// Top level of the two-tap adpcm frame decoder.
// Each sample passes a product stage, then accumulate and clip, as the history
// feedback loop through the multipliers sets the pace.
// A discarded frame still steps through all of its samples to advance the history.
// Results pass the job queue, product and accumulate stages to the output register;
// a two-entry job queue lets items be accepted while a frame is decoding.
// Asynchronous active-low reset clears configuration, history, queue and control.
module adpcm_two_tap_frame_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // [63:0] frame_bytes, [67:64] sample_count, zero pad
	input  logic [1:0]  s_tuser,   // [0] discard, [1] restart
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] pcm_sample
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	acd_pkg::acd_cfg_t cfg;
	acd_pkg::acd_job_t job;
	logic              job_valid;
	logic              job_pop;

	// configuration registers
	acd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// item intake and job queue
	acd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.frame_bytes  (s_tdata[63:0]),
		.sample_count (s_tdata[67:64]),
		.discard      (s_tuser[0]),
		.restart      (s_tuser[1]),
		.job_valid    (job_valid),
		.job          (job),
		.job_pop      (job_pop)
	);

	// sample decoding
	acd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.job_valid  (job_valid),
		.job        (job),
		.job_pop    (job_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.pcm_sample (m_tdata),
		.last       (m_tlast)
	);

endmodule

// File: verif/tb_adpcm_two_tap_frame_decoder.sv
// self-checking testbench of the two-tap adpcm frame decoder
module tb_adpcm_two_tap_frame_decoder;
	timeunit 1ns;
	timeprecision 1ps;

	// one decoded pcm item as it should leave the block
	typedef struct {
		logic signed [15:0] pcm;
		logic               last;
	} pcm_item_t;

	typedef enum {COEF_TYPICAL, COEF_MAX, COEF_MIN, COEF_WILD} coef_style_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;   // [63:0] frame_bytes, [67:64] sample_count, zero pad
	logic [1:0]  s_tuser;   // [0] discard, [1] restart
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // [15:0] pcm_sample
	logic        m_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;

	// decoder copy of configuration and history
	acd_pkg::acd_cfg_t  dec_cfg;
	logic signed [15:0] dec_hist_newer;
	logic signed [15:0] dec_hist_older;
	pcm_item_t          pcm_expected[$];

	int fail_count;
	bit send_calm;
	bit recv_calm;
	bit hold_request;
	int hold_left;

	adpcm_two_tap_frame_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// clock
	always #2 clk = ~clk;

	// work out the samples one accepted frame gives and advance the history
	function automatic void decode_frame(input logic [63:0] frame, input logic [3:0] count,
		input logic discard, input logic restart);
		logic [2:0]         pair;
		logic [3:0]         expo;
		logic signed [15:0] c1;
		logic signed [15:0] c2;
		logic signed [3:0]  nib;
		longint             acc;
		longint             s;
		int                 total;
		int                 k;
		pcm_item_t          item;
		pair = frame[62:60];
		expo = frame[59:56];
		k = 2 * pair;
		c1 = dec_cfg.coef_word[k / 4][(k % 4) * 16 +: 16];
		c2 = dec_cfg.coef_word[(k + 1) / 4][((k + 1) % 4) * 16 +: 16];
		if (restart) begin
			dec_hist_newer = dec_cfg.start_hist_newer;
			dec_hist_older = dec_cfg.start_hist_older;
		end
		if (discard)
			total = acd_pkg::SAMPLES_PER_FRAME;
		else
			total = (count > acd_pkg::SAMPLES_PER_FRAME) ? acd_pkg::SAMPLES_PER_FRAME :
				int'(count);
		for (int n = 0; n < total; n++) begin
			nib = frame[55 - 4 * n -: 4];
			acc = longint'(dec_hist_newer) * c1 + longint'(dec_hist_older) * c2;
			s = (acc >>> 11) + (longint'(nib) <<< expo);
			if (s < -32768)
				s = -32768;
			if (s > 32767)
				s = 32767;
			dec_hist_older = dec_hist_newer;
			dec_hist_newer = s[15:0];
			if (!discard) begin
				item.pcm = s[15:0];
				item.last = (n == total - 1);
				pcm_expected.push_back(item);
			end
		end
	endfunction

	// check every pcm item that leaves the block
	always @(posedge clk) begin
		pcm_item_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pcm_expected.size() == 0) begin
				$error("unexpected pcm item %0d", $signed(m_tdata));
				fail_count++;
			end else begin
				want = pcm_expected.pop_front();
				if (m_tdata !== want.pcm) begin
					$error("pcm_sample mismatch: expected %0d, got %0d", want.pcm,
						$signed(m_tdata));
					fail_count++;
				end
				if (m_tlast !== want.last) begin
					$error("last mismatch: expected %0d, got %0d", want.last, m_tlast);
					fail_count++;
				end
			end
		end
	end

	// receiver: random stalls, calm stretches and one long hold-off
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (hold_request) begin
			hold_request = 0;
			hold_left = 300;
			m_tready <= 1'b0;
		end else if (recv_calm)
			m_tready <= 1'b1;
		else
			m_tready <= ($urandom_range(0, 99) >= 20);
	end

	// write one configuration register and mirror it
	task automatic write_reg(input logic [2:0] index, input logic [63:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (index)
			acd_pkg::REG_COEF_WORD_0, acd_pkg::REG_COEF_WORD_1, acd_pkg::REG_COEF_WORD_2,
			acd_pkg::REG_COEF_WORD_3:
				dec_cfg.coef_word[index[1:0]] = data;
			acd_pkg::REG_START_HIST_NEWER: dec_cfg.start_hist_newer = data[15:0];
			acd_pkg::REG_START_HIST_OLDER: dec_cfg.start_hist_older = data[15:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// offer one frame item, leaving tvalid high for a following item
	task automatic send_frame(input logic [63:0] frame, input logic [3:0] count,
		input logic discard, input logic restart);
		int gap;
		gap = (!send_calm && $urandom_range(0, 99) < 20) ? $urandom_range(1, 6) : 0;
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, count, frame};
		s_tuser <= {restart, discard};
		do @(posedge clk); while (!s_tready);
		decode_frame(frame, count, discard, restart);
	endtask

	// stop offering and let the block drain, including frames with no output
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pcm_expected.size() != 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic program_decoder(input coef_style_t style);
		logic [63:0] word;
		for (int w = 0; w < 4; w++) begin
			case (style)
				COEF_MAX: word = {4{16'h7FFF}};
				COEF_MIN: word = {4{16'h8000}};
				COEF_WILD: word = {$urandom, $urandom};
				default:
					for (int c = 0; c < 4; c++)
						word[c * 16 +: 16] = 16'($urandom_range(0, 8191) - 4096);
			endcase
			write_reg(acd_pkg::REG_COEF_WORD_0 + 3'(w), word);
		end
		case (style)
			COEF_MAX: begin
				write_reg(acd_pkg::REG_START_HIST_NEWER, 64'h7FFF);
				write_reg(acd_pkg::REG_START_HIST_OLDER, 64'h7FFF);
			end
			COEF_MIN: begin
				write_reg(acd_pkg::REG_START_HIST_NEWER, 64'h8000);
				write_reg(acd_pkg::REG_START_HIST_OLDER, 64'h8000);
			end
			default: begin
				write_reg(acd_pkg::REG_START_HIST_NEWER, {$urandom, $urandom});
				write_reg(acd_pkg::REG_START_HIST_OLDER, {$urandom, $urandom});
			end
		endcase
	endtask

	// one random frame item, mostly decoding runs with the odd restart
	task automatic send_random_frame();
		logic [3:0] count;
		if ($urandom_range(0, 19) == 0)
			count = $urandom_range(0, 1) ? 4'd0 : 4'd15;
		else
			count = 4'($urandom_range(1, 14));
		send_frame({$urandom, $urandom}, count, $urandom_range(0, 99) < 10,
			$urandom_range(0, 99) < 15);
	endtask

	// nibble and exponent extremes with the reset configuration
	task automatic test_nibble_extremes();
		send_frame(64'h0F78787878787878, 4'd14, 1'b0, 1'b0);
		send_frame(64'h0078787878787878, 4'd1, 1'b0, 1'b0);
		send_frame(64'h0087878787878787, 4'd14, 1'b0, 1'b0);
		send_frame(64'h0000000000000000, 4'd14, 1'b0, 1'b0);
		send_frame(64'h8FFFFFFFFFFFFFFF, 4'd14, 1'b0, 1'b0);
		settle();
	endtask

	// restart, discard, empty and oversized counts, every coefficient pair
	task automatic test_special_cases();
		write_reg(acd_pkg::REG_COEF_WORD_0, {16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF});
		write_reg(acd_pkg::REG_COEF_WORD_1, {4{16'h8000}});
		write_reg(acd_pkg::REG_COEF_WORD_2, {16'hFC4A, 16'h04AB, 16'hF800, 16'h0800});
		write_reg(acd_pkg::REG_COEF_WORD_3, {$urandom, $urandom});
		write_reg(acd_pkg::REG_START_HIST_NEWER, 64'h7FFF);
		write_reg(acd_pkg::REG_START_HIST_OLDER, 64'h8000);
		send_frame(64'h0312345678ABCDEF, 4'd5, 1'b1, 1'b1);
		send_frame(64'h0012345678ABCDEF, 4'd14, 1'b0, 1'b0);
		send_frame(64'h1BF0E1D2C3B4A596, 4'd14, 1'b1, 1'b0);
		send_frame(64'h2276543210FEDC, 4'd0, 1'b0, 1'b1);
		send_frame(64'h02123456789ABCDE, 4'd3, 1'b0, 1'b0);
		send_frame(64'h0455555555555555, 4'd0, 1'b0, 1'b0);
		send_frame(64'h0F7F7F7F7F7F7F7F, 4'd15, 1'b0, 1'b1);
		for (int p = 0; p < 8; p++)
			send_frame({1'b1, 3'(p), 4'd2, 24'($urandom), 32'($urandom)}, 4'd2,
				1'b0, p[0]);
		settle();
	endtask

	task automatic test_random_frames(input coef_style_t style, input int n_items);
		program_decoder(style);
		send_frame({$urandom, $urandom}, 4'd14, 1'b0, 1'b1);
		for (int i = 1; i < n_items; i++)
			send_random_frame();
		settle();
	endtask

	// receiver holds off while frames keep coming, so the input stalls
	task automatic test_backpressure();
		send_calm = 1;
		hold_request = 1;
		for (int i = 0; i < 20; i++)
			send_random_frame();
		send_calm = 0;
		settle();
	endtask

	// back to back with no idling on either side
	task automatic test_full_rate();
		send_calm = 1;
		recv_calm = 1;
		for (int i = 0; i < 45; i++)
			send_random_frame();
		send_calm = 0;
		recv_calm = 0;
		settle();
	endtask

	// reset, then the tests in turn
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = acd_pkg::REG_COEF_WORD_0;
		cfg_data = '0;
		dec_cfg = '0;
		dec_hist_newer = '0;
		dec_hist_older = '0;
		fail_count = 0;
		send_calm = 0;
		recv_calm = 0;
		hold_request = 0;
		hold_left = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (4) @(posedge clk);

		test_nibble_extremes();
		test_special_cases();
		test_random_frames(COEF_TYPICAL, 60);
		test_random_frames(COEF_MAX, 50);
		test_random_frames(COEF_MIN, 50);
		test_random_frames(COEF_WILD, 55);
		test_backpressure();
		test_full_rate();

		if (fail_count == 0)
			$display("adpcm_two_tap_frame_decoder verification clean");
		else
			$display("adpcm_two_tap_frame_decoder verification failed");
		$finish;
	end

	// run limit
	initial begin
		#2ms;
		$display("adpcm_two_tap_frame_decoder verification failed");
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/acd_pkg.sv
rtl/core/acd_cfg.sv
rtl/core/acd_front.sv
rtl/core/acd_back.sv
rtl/core/adpcm_two_tap_frame_decoder.sv
verif/tb_adpcm_two_tap_frame_decoder.sv
